/* hw/rtl/sme_pkg.sv */
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int unsigned StackDepthDefault = 1024;
	localparam int unsigned WordW = 64;

	localparam logic [3:0] OP_NOP = 4'd0;
	localparam logic [3:0] OP_POP = 4'd1;
	localparam logic [3:0] OP_PSH = 4'd2;
	localparam logic [3:0] OP_DUP = 4'd3;
	localparam logic [3:0] OP_ADD = 4'd4;
	localparam logic [3:0] OP_SUB = 4'd5;
	localparam logic [3:0] OP_MUL = 4'd6;
	localparam logic [3:0] OP_DIV = 4'd7;
	localparam logic [3:0] OP_EQL = 4'd8;
	localparam logic [3:0] OP_JMP = 4'd9;
	localparam logic [3:0] OP_JNZ = 4'd10;
	localparam logic [3:0] OP_HLT = 4'd11;

	localparam logic [2:0] E_OK     = 3'd0;
	localparam logic [2:0] E_OVER   = 3'd1;
	localparam logic [2:0] E_UNDER  = 3'd2;
	localparam logic [2:0] E_DIVZ   = 3'd3;
	localparam logic [2:0] E_OPND   = 3'd4;
	localparam logic [2:0] E_ACCESS = 3'd5;
	localparam logic [2:0] E_INST   = 3'd6;

	typedef struct packed {
		logic [3:0]        op;
		logic signed [63:0] operand;
	} req_t;

	typedef struct packed {
		logic [2:0]         error_code;
		logic signed [63:0] next_pointer;
		logic               halted;
		logic               popped_valid;
		logic signed [63:0] popped_value;
	} rsp_t;

endpackage

/* hw/rtl/sme_ram.sv */
// ----------------------------------------------------------------------------
// sme_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sme_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hw/rtl/sme_div.sv */
// ----------------------------------------------------------------------------
// sme_div
// Signed truncating 64-bit divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic        neg_q;
	logic [64:0] trial;
	logic [63:0] rem_sh;

	assign rem_sh = {rem_q[62:0], quo_q[63]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[63] ? (64'd0 - dividend) : dividend;
			dvs_q <= divisor[63] ? (64'd0 - divisor) : divisor;
			neg_q <= dividend[63] ^ divisor[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

/* hw/rtl/stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes one fetched instruction per request against a word stack held in
// a single-port RAM, with the top entry cached in a register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | sme_pkg::req_t
//  rsp     | out       | rsp_valid/stall  | sme_pkg::rsp_t
//  cfg     | in        | cfg_valid/ready  | program_length, 16 bits
// A request passes through accept, RAM read of the second entry, execute and
// write back, then the response register; the next request is taken the
// cycle after the response leaves. Multiply adds the ST_MUL and ST_MUL2
// states of 32-bit partial products; divide waits in ST_DIV for the
// bit-serial divider. The stack RAM is not cleared after reset.
// While the response is stalled no new request is taken.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit #(
	parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sme_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sme_pkg::rsp_t  rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [15:0]    cfg_data
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [2:0] ST_MUL2 = 3'd6;

	logic [2:0]    state_q;
	logic [15:0]   plen_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   ip_q;
	logic          halt_q;
	logic [63:0]   top_q;
	logic [3:0]    op_q;
	logic [63:0]   opnd_q;
	sme_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;
	logic [63:0]   mul_q;
	logic [63:0]   mul_a_q;

	logic [31:0]   mul_ma;
	logic [31:0]   mul_mb;
	logic [63:0]   mul_p;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [63:0]   ram_wdata;
	logic [63:0]   ram_rdata;

	logic          div_start;
	logic          div_done;
	logic [63:0]   div_quo;

	logic          acc;
	logic          ip_bad;
	logic [CW-1:0] rd_idx;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || rsp_valid_q;
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign ip_bad    = ip_q[63] || (ip_q >= {48'd0, plen_q});

	sme_ram #(.Width(64), .Depth(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ram_rdata),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// RAM entry to read for the second operand or dup source (top-1-depth)
	always_comb begin
		if (op_q == sme_pkg::OP_DUP) begin
			rd_idx = cnt_q - CW'(1) - opnd_q[CW-1:0];
		end else begin
			rd_idx = cnt_q - CW'(2);
		end
	end

	// low product, then the two cross terms into the upper half
	always_comb begin
		case (state_q)
			ST_EXEC: begin
				mul_ma = ram_rdata[31:0];
				mul_mb = top_q[31:0];
			end
			ST_MUL: begin
				mul_ma = mul_a_q[63:32];
				mul_mb = top_q[31:0];
			end
			default: begin
				mul_ma = mul_a_q[31:0];
				mul_mb = top_q[63:32];
			end
		endcase
	end

	assign mul_p = {32'd0, mul_ma} * {32'd0, mul_mb};

	// Execute stage (ST_EXEC) decides everything except mul/div writeback.
	logic [2:0]    x_err;
	logic          x_adv;
	logic          x_jump;
	logic          x_halt;
	logic          x_pop;
	logic [CW-1:0] x_cnt;
	logic          x_topw;
	logic [63:0]   x_top;
	logic          x_memw;
	logic [AW-1:0] x_maddr;
	logic [63:0]   x_mdata;
	logic          x_mul;
	logic          x_div;

	always_comb begin
		x_err   = sme_pkg::E_OK;
		x_adv   = 1'b1;
		x_jump  = 1'b0;
		x_halt  = 1'b0;
		x_pop   = 1'b0;
		x_cnt   = cnt_q;
		x_topw  = 1'b0;
		x_top   = top_q;
		x_memw  = 1'b0;
		x_maddr = cnt_q[AW-1:0];
		x_mdata = top_q;
		x_mul   = 1'b0;
		x_div   = 1'b0;
		if (ip_bad) begin
			x_err = sme_pkg::E_ACCESS;
		end else begin
			case (op_q)
				sme_pkg::OP_NOP: begin
				end
				sme_pkg::OP_POP: begin
					if (cnt_q == '0) begin
						x_err = sme_pkg::E_UNDER;
					end else begin
						x_pop  = 1'b1;
						x_cnt  = cnt_q - CW'(1);
						x_topw = 1'b1;
						x_top  = ram_rdata;
					end
				end
				sme_pkg::OP_PSH: begin
					if (cnt_q >= FULL) begin
						x_err = sme_pkg::E_OVER;
					end else begin
						x_cnt   = cnt_q + CW'(1);
						x_topw  = 1'b1;
						x_top   = opnd_q;
						x_memw  = (cnt_q != '0);
						x_maddr = AW'(cnt_q - CW'(1));
					end
				end
				sme_pkg::OP_DUP: begin
					if (cnt_q >= FULL) begin
						x_err = sme_pkg::E_OVER;
					end else if (opnd_q[63]) begin
						x_err = sme_pkg::E_OPND;
					end else if (cnt_q == '0 || opnd_q >= 64'(cnt_q)) begin
						x_err = sme_pkg::E_UNDER;
					end else begin
						x_cnt   = cnt_q + CW'(1);
						x_topw  = 1'b1;
						x_top   = (opnd_q == 64'd0) ? top_q : ram_rdata;
						x_memw  = 1'b1;
						x_maddr = AW'(cnt_q - CW'(1));
					end
				end
				sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
				sme_pkg::OP_DIV, sme_pkg::OP_EQL: begin
					if (cnt_q < CW'(2)) begin
						x_err = sme_pkg::E_UNDER;
					end else if (op_q == sme_pkg::OP_DIV && top_q == 64'd0) begin
						x_err = sme_pkg::E_DIVZ;
					end else begin
						x_cnt  = cnt_q - CW'(1);
						x_topw = 1'b1;
						x_mul  = (op_q == sme_pkg::OP_MUL);
						x_div  = (op_q == sme_pkg::OP_DIV);
						case (op_q)
							sme_pkg::OP_ADD: x_top = ram_rdata + top_q;
							sme_pkg::OP_SUB: x_top = ram_rdata - top_q;
							sme_pkg::OP_EQL: x_top = {63'd0, ram_rdata == top_q};
							default:         x_top = top_q;
						endcase
					end
				end
				sme_pkg::OP_JMP: begin
					x_adv  = 1'b0;
					x_jump = 1'b1;
				end
				sme_pkg::OP_JNZ: begin
					if (cnt_q == '0) begin
						x_err = sme_pkg::E_UNDER;
					end else if (top_q != 64'd0) begin
						x_adv  = 1'b0;
						x_jump = 1'b1;
						x_cnt  = cnt_q - CW'(1);
						x_topw = 1'b1;
						x_top  = ram_rdata;
					end
				end
				sme_pkg::OP_HLT: begin
					x_adv  = 1'b0;
					x_halt = 1'b1;
				end
				default: x_err = sme_pkg::E_INST;
			endcase
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = AW'(rd_idx);
		ram_wdata = x_mdata;
		div_start = 1'b0;
		if (state_q == ST_EXEC) begin
			ram_we    = x_memw && (x_err == sme_pkg::E_OK);
			ram_addr  = x_maddr;
			div_start = x_div && (x_err == sme_pkg::E_OK);
		end else if (state_q inside {ST_DIV, ST_MUL, ST_MUL2}) begin
			ram_addr = AW'(rd_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plen_q      <= '0;
			cnt_q       <= '0;
			ip_q        <= '0;
			halt_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				plen_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (x_err == sme_pkg::E_OK) begin
						cnt_q <= x_cnt;
						if (x_halt) begin
							halt_q <= 1'b1;
						end
						if (x_jump) begin
							ip_q <= opnd_q;
						end else if (x_adv) begin
							ip_q <= ip_q + 64'd1;
						end
					end
					if (x_err == sme_pkg::E_OK && x_mul) begin
						state_q <= ST_MUL;
					end else if (x_err == sme_pkg::E_OK && x_div) begin
						state_q <= ST_DIV;
					end else begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				ST_MUL: state_q <= ST_MUL2;
				ST_MUL2: begin
					state_q     <= ST_IDLE;
					rsp_valid_q <= 1'b1;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q   <= req.op;
			opnd_q <= req.operand;
		end
		if (state_q == ST_EXEC) begin
			mul_q   <= mul_p;
			mul_a_q <= ram_rdata;
			if (x_err == sme_pkg::E_OK && x_topw && !x_mul && !x_div) begin
				top_q <= x_top;
			end
			rsp_q.error_code   <= x_err;
			rsp_q.halted       <= halt_q || (x_halt && x_err == sme_pkg::E_OK);
			rsp_q.popped_valid <= x_pop;
			rsp_q.popped_value <= x_pop ? top_q : 64'd0;
			if (x_err != sme_pkg::E_OK) begin
				rsp_q.next_pointer <= ip_q;
			end else if (x_jump) begin
				rsp_q.next_pointer <= opnd_q;
			end else if (x_adv) begin
				rsp_q.next_pointer <= ip_q + 64'd1;
			end else begin
				rsp_q.next_pointer <= ip_q;
			end
		end
		if (state_q == ST_MUL) begin
			mul_q <= mul_q + {mul_p[31:0], 32'd0};
		end
		if (state_q == ST_MUL2) begin
			top_q <= mul_q + {mul_p[31:0], 32'd0};
		end
		if (state_q == ST_DIV && div_done) begin
			top_q <= div_quo;
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL)
		else $error("stack count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> state_q == ST_IDLE)
		else $error("response pending while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && x_err != sme_pkg::E_OK) |=> $stable(cnt_q) && $stable(ip_q))
		else $error("state changed on error");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == ST_READ)
		else $error("accepted request not started");
`endif

endmodule

/* dv/tb_stack_machine_executor_unit.sv */
// ----------------------------------------------------------------------------
// tb_stack_machine_executor_unit
// Self-checking bench for the stack machine executor: a predictor tracks stack,
// pointer, halt flag and program length, and every response is compared with
// the oldest predicted one, with randomized request gaps and response stalls in the random mix.
// ----------------------------------------------------------------------------
module tb_stack_machine_executor_unit;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam logic [3:0] OP_BAD_LO = 4'd12;
	localparam logic signed [63:0] WORD_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] WORD_MAX = 64'sh7fff_ffff_ffff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	sme_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sme_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic [63:0] stack_mem [DEPTH];
	int unsigned depth_used = 0;
	logic [63:0] ip_model = '0;
	logic halt_model = 1'b0;
	logic [15:0] prog_len = '0;

	sme_pkg::rsp_t pending_rsp [$];
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned fail_count = 0;
	int unsigned instr_count = 0;
	int unsigned rsp_count = 0;
	int unsigned cycle_count = 0;

	stack_machine_executor_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic sme_pkg::rsp_t execute_instr(sme_pkg::req_t r);
		sme_pkg::rsp_t o;
		logic signed [63:0] a, b, q;
		logic go_next;
		o = '0;
		o.error_code = sme_pkg::E_OK;
		go_next = 1'b1;
		if (ip_model[63] || ip_model >= {48'd0, prog_len}) begin
			o.error_code = sme_pkg::E_ACCESS;
			go_next = 1'b0;
		end else begin
			case (r.op)
				sme_pkg::OP_NOP: ;
				sme_pkg::OP_POP: begin
					if (depth_used < 1) o.error_code = sme_pkg::E_UNDER;
					else begin
						depth_used--;
						o.popped_value = stack_mem[depth_used];
						o.popped_valid = 1'b1;
					end
				end
				sme_pkg::OP_PSH: begin
					if (depth_used >= DEPTH) o.error_code = sme_pkg::E_OVER;
					else begin
						stack_mem[depth_used] = r.operand;
						depth_used++;
					end
				end
				sme_pkg::OP_DUP: begin
					if (depth_used >= DEPTH) o.error_code = sme_pkg::E_OVER;
					else if (r.operand[63]) o.error_code = sme_pkg::E_OPND;
					else if (r.operand >= 64'(depth_used)) o.error_code = sme_pkg::E_UNDER;
					else begin
						stack_mem[depth_used] = stack_mem[depth_used - 1 - int'(r.operand)];
						depth_used++;
					end
				end
				sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
				sme_pkg::OP_EQL: begin
					if (depth_used < 2) o.error_code = sme_pkg::E_UNDER;
					else begin
						a = stack_mem[depth_used - 2];
						b = stack_mem[depth_used - 1];
						if (r.op == sme_pkg::OP_DIV && b == 0) o.error_code = sme_pkg::E_DIVZ;
						else begin
							case (r.op)
								sme_pkg::OP_ADD: q = a + b;
								sme_pkg::OP_SUB: q = a - b;
								sme_pkg::OP_MUL: q = a * b;
								sme_pkg::OP_DIV:
									q = (a == WORD_MIN && b == -64'sd1) ? a : a / b;
								default: q = (a == b) ? 64'sd1 : 64'sd0;
							endcase
							stack_mem[depth_used - 2] = q;
							depth_used--;
						end
					end
				end
				sme_pkg::OP_JMP: begin
					ip_model = r.operand;
					go_next = 1'b0;
				end
				sme_pkg::OP_JNZ: begin
					if (depth_used < 1) o.error_code = sme_pkg::E_UNDER;
					else if (stack_mem[depth_used - 1] != 0) begin
						depth_used--;
						ip_model = r.operand;
						go_next = 1'b0;
					end
				end
				sme_pkg::OP_HLT: begin
					halt_model = 1'b1;
					go_next = 1'b0;
				end
				default: o.error_code = sme_pkg::E_INST;
			endcase
			if (o.error_code == sme_pkg::E_OK && go_next) ip_model = ip_model + 1;
		end
		o.next_pointer = ip_model;
		o.halted = halt_model;
		return o;
	endfunction

	task automatic send_instr(input logic [3:0] op, input logic signed [63:0] val);
		if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			req <= '{op: 4'($urandom), operand: {$urandom, $urandom}};
			@(posedge clk);
			while ($urandom_range(99) < send_gap_pct) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op: op, operand: val};
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(execute_instr('{op: op, operand: val}));
		instr_count++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(input logic [15:0] len);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		prog_len = len;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on response %0d: %s got %h expected %h",
			rsp_count, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		sme_pkg::rsp_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected response", 64'd1, 64'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.error_code !== want.error_code)
					report_mismatch("error_code", 64'(rsp.error_code), 64'(want.error_code));
				if (rsp.next_pointer !== want.next_pointer)
					report_mismatch("next_pointer", rsp.next_pointer, want.next_pointer);
				if (rsp.halted !== want.halted)
					report_mismatch("halted", 64'(rsp.halted), 64'(want.halted));
				if (rsp.popped_valid !== want.popped_valid)
					report_mismatch("popped_valid", 64'(rsp.popped_valid),
						64'(want.popped_valid));
				if (rsp.popped_value !== want.popped_value)
					report_mismatch("popped_value", rsp.popped_value, want.popped_value);
			end
			rsp_count++;
		end
		rsp_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
	end

	task automatic test_access_check();
		send_instr(sme_pkg::OP_NOP, 0);
		set_length(16'd1);
		send_instr(sme_pkg::OP_NOP, 0);
		send_instr(sme_pkg::OP_NOP, 0);
		set_length(16'hffff);
	endtask

	task automatic test_directed_ops();
		send_instr(sme_pkg::OP_POP, 0);
		send_instr(sme_pkg::OP_JNZ, 5);
		send_instr(sme_pkg::OP_PSH, WORD_MAX);
		send_instr(sme_pkg::OP_PSH, WORD_MIN);
		send_instr(sme_pkg::OP_DUP, -64'sd1);
		send_instr(sme_pkg::OP_DUP, 2);
		send_instr(sme_pkg::OP_DUP, 1);
		send_instr(sme_pkg::OP_ADD, 0);
		send_instr(sme_pkg::OP_PSH, -64'sd1);
		send_instr(sme_pkg::OP_DIV, 0);
		send_instr(sme_pkg::OP_PSH, 0);
		send_instr(sme_pkg::OP_DIV, 0);
		send_instr(sme_pkg::OP_POP, 0);
		send_instr(sme_pkg::OP_PSH, -64'sd7);
		send_instr(sme_pkg::OP_DIV, 0);
		send_instr(sme_pkg::OP_PSH, 3);
		send_instr(sme_pkg::OP_MUL, 0);
		send_instr(sme_pkg::OP_DUP, 0);
		send_instr(sme_pkg::OP_SUB, 0);
		send_instr(sme_pkg::OP_JNZ, 40);
		send_instr(sme_pkg::OP_DUP, 0);
		send_instr(sme_pkg::OP_EQL, 0);
		send_instr(sme_pkg::OP_JNZ, 100);
		send_instr(sme_pkg::OP_JMP, 7);
		send_instr(sme_pkg::OP_HLT, 0);
		for (int i = 0; i < 4; i++) send_instr(OP_BAD_LO + 4'(i), 0);
		send_instr(sme_pkg::OP_NOP, 0);
	endtask

	task automatic test_stack_full();
		while (depth_used < DEPTH) send_instr(sme_pkg::OP_PSH, {$urandom, $urandom});
		send_instr(sme_pkg::OP_PSH, 1);
		send_instr(sme_pkg::OP_DUP, 0);
		while (depth_used > DEPTH - 8) send_instr(sme_pkg::OP_POP, 0);
	endtask

	task automatic random_instr();
		int unsigned pick;
		logic signed [63:0] val;
		pick = $urandom_range(99);
		val = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(3));
		if (pick < 24) send_instr(sme_pkg::OP_PSH, val);
		else if (pick < 34) send_instr(sme_pkg::OP_POP, 0);
		else if (pick < 44)
			send_instr(sme_pkg::OP_DUP,
				($urandom_range(9) == 0) ? val : 64'($urandom_range(depth_used)));
		else if (pick < 52) send_instr(sme_pkg::OP_ADD, 0);
		else if (pick < 59) send_instr(sme_pkg::OP_SUB, 0);
		else if (pick < 66) send_instr(sme_pkg::OP_MUL, 0);
		else if (pick < 71) send_instr(sme_pkg::OP_DIV, 0);
		else if (pick < 79) send_instr(sme_pkg::OP_EQL, 0);
		else if (pick < 84) send_instr(sme_pkg::OP_JMP, 64'($urandom_range(4000)));
		else if (pick < 92) send_instr(sme_pkg::OP_JNZ, 64'($urandom_range(4000)));
		else if (pick < 94) send_instr(sme_pkg::OP_HLT, 0);
		else if (pick < 97) send_instr(sme_pkg::OP_NOP, val);
		else send_instr(4'($urandom_range(15, 12)), val);
	endtask

	task automatic test_random_mix();
		int unsigned gaps [4] = '{0, 68, 0, 29};
		int unsigned stalls [4] = '{0, 0, 68, 29};
		logic [15:0] lens [4] = '{16'hffff, 16'd3000, 16'd40000, 16'hffff};
		for (int ph = 0; ph < 4; ph++) begin
			set_length(lens[ph]);
			send_gap_pct = gaps[ph];
			stall_pct = stalls[ph];
			repeat (125) random_instr();
		end
		send_gap_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_negative_pointer();
		set_length(16'hffff);
		send_instr(sme_pkg::OP_JMP, -64'sd5);
		send_instr(sme_pkg::OP_NOP, 0);
		send_instr(sme_pkg::OP_PSH, 1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_access_check();
		test_directed_ops();
		test_stack_full();
		test_random_mix();
		test_negative_pointer();
		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d instructions and %0d responses: all opcodes, error codes,",
			instr_count, rsp_count);
		$display("full and empty stack, program length changes and handshake stalls");
		if (fail_count == 0 && pending_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
